### rtl/b2da_pkg.sv
// b2da_pkg: types, constants and helper functions of the binary to decimal ascii unit
// no dependencies; used by the front, queue, back and top level files
`timescale 1ns / 1ps

package b2da_pkg;

	localparam int BIN_W          = 16;
	localparam int NIBBLES        = 5;
	localparam int BCD_W          = 4 * NIBBLES;
	localparam int CNT_W          = 3;
	localparam int CHAR_W         = 6;
	localparam int BITS_PER_STAGE = 4;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// one queued word: digits left-aligned so the first digit sent sits on top
	typedef struct packed {
		logic [BCD_W-1:0] digits;
		logic [CNT_W-1:0] count;
	} entry_t;

	// push side of the queue
	typedef struct packed {
		logic   push;
		entry_t entry;
	} push_t;

	// four double-dabble steps: correct every nibble, then shift one bit in
	function automatic logic [BCD_W-1:0] dabble4(
		input logic [BCD_W-1:0]          bcd_in,
		input logic [BITS_PER_STAGE-1:0] bits
	);
		logic [BCD_W-1:0] b;
		b = bcd_in;
		for (int s = BITS_PER_STAGE - 1; s >= 0; s--) begin
			for (int n = 0; n < NIBBLES; n++) begin
				if (b[4*n +: 4] >= 4'd5) begin
					b[4*n +: 4] = b[4*n +: 4] + 4'd3;
				end
			end
			b = {b[BCD_W-2:0], bits[s]};
		end
		return b;
	endfunction

	// digit count and left alignment, leading zeros dropped, zero keeps one digit
	function automatic entry_t classify(input logic [BCD_W-1:0] bcd);
		entry_t e;
		if (bcd[19:16] != 4'd0) begin
			e.count  = 3'd5;
			e.digits = bcd;
		end else if (bcd[15:12] != 4'd0) begin
			e.count  = 3'd4;
			e.digits = {bcd[15:0], 4'd0};
		end else if (bcd[11:8] != 4'd0) begin
			e.count  = 3'd3;
			e.digits = {bcd[11:0], 8'd0};
		end else if (bcd[7:4] != 4'd0) begin
			e.count  = 3'd2;
			e.digits = {bcd[7:0], 12'd0};
		end else begin
			e.count  = 3'd1;
			e.digits = {bcd[3:0], 16'd0};
		end
		return e;
	endfunction

endpackage

### rtl/b2da_front.sv
// b2da_front: four-stage double-dabble pipeline that converts and classifies each word
// depends on b2da_pkg
`timescale 1ns / 1ps

module b2da_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [b2da_pkg::BIN_W-1:0]   value,
	output b2da_pkg::push_t              push_out
);

	logic                        valid_s1, valid_s2, valid_s3, valid_s4;
	logic [b2da_pkg::BCD_W-1:0]  bcd_s1, bcd_s2, bcd_s3, bcd_s4;
	logic [11:0]                 rem_s1;
	logic [7:0]                  rem_s2;
	logic [3:0]                  rem_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// four input bits per stage, msb first
	always_ff @(posedge clk) begin
		bcd_s1 <= b2da_pkg::dabble4('0, value[15:12]);
		rem_s1 <= value[11:0];
		bcd_s2 <= b2da_pkg::dabble4(bcd_s1, rem_s1[11:8]);
		rem_s2 <= rem_s1[7:0];
		bcd_s3 <= b2da_pkg::dabble4(bcd_s2, rem_s2[7:4]);
		rem_s3 <= rem_s2[3:0];
		bcd_s4 <= b2da_pkg::dabble4(bcd_s3, rem_s3);
	end

	assign push_out.push  = valid_s4;
	assign push_out.entry = b2da_pkg::classify(bcd_s4);

endmodule

### rtl/b2da_queue.sv
// b2da_queue: small first-in first-out store between front and back
// depends on b2da_pkg
`timescale 1ns / 1ps

module b2da_queue #(
	parameter int DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  b2da_pkg::push_t   push_in,
	input  logic              pop,
	output b2da_pkg::entry_t  head,
	output logic              empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b2da_pkg::entry_t   mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push_in.push) begin
			mem[wr_ptr_q] <= push_in.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_in.push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push_in.push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head  = mem[rd_ptr_q];
	assign empty = (cnt_q == '0);

endmodule

### rtl/b2da_back.sv
// b2da_back: digit serialiser that sends one ascii character per cycle while a word is loaded
// depends on b2da_pkg
`timescale 1ns / 1ps

module b2da_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  b2da_pkg::entry_t              head,
	input  logic                          empty,
	output logic                          pop,
	output logic                          strobe,
	output logic [b2da_pkg::CHAR_W-1:0]   digit_char,
	output logic                          last
);

	logic                               cur_valid_q;
	logic [b2da_pkg::BCD_W-1:0]         digits_q;
	logic [b2da_pkg::CNT_W-1:0]         left_q;
	logic                               strobe_q;
	logic [b2da_pkg::CHAR_W-1:0]        char_q;
	logic                               last_q;
	logic                               final_digit;

	assign final_digit = cur_valid_q && (left_q == b2da_pkg::CNT_W'(1));
	// take the next word when idle or on the last digit of the current one
	assign pop         = !empty && (!cur_valid_q || final_digit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			left_q      <= '0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= cur_valid_q;
			if (pop) begin
				cur_valid_q <= 1'b1;
				left_q      <= head.count;
			end else if (cur_valid_q) begin
				cur_valid_q <= !final_digit;
				left_q      <= left_q - b2da_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cur_valid_q) begin
			char_q <= b2da_pkg::ASCII_ZERO + {2'b00, digits_q[19:16]};
			last_q <= final_digit;
		end
		if (pop) begin
			digits_q <= head.digits;
		end else if (cur_valid_q) begin
			digits_q <= {digits_q[15:0], 4'd0};
		end
	end

	assign strobe     = strobe_q;
	assign digit_char = char_q;
	assign last       = last_q;

endmodule

### rtl/binary_to_decimal_ascii_unit.sv
// binary_to_decimal_ascii_unit: top level, front pipeline, queue and digit serialiser
// depends on b2da_pkg, b2da_front, b2da_queue and b2da_back
`timescale 1ns / 1ps

// usage
//   a 16-bit word is taken on value at a rising edge where start is high and busy is low
//   its decimal text leaves on digit_char, most significant digit first, leading zeros
//   dropped (zero gives one '0'); each character is shown for exactly one cycle with
//   strobe high, and last is high on the least significant digit
//   the accepting edge loads the first of the 4 double-dabble stages; the word then passes
//     the other stages, the queue write and the serialiser load, and its first character
//     reaches the ports through the output register
//   throughput: one character per cycle while a word is loaded, so a word gives 1 to 5
//     characters, one per digit; queued words run back to back with no gap between runs
//   busy rises when QUEUE_DEPTH words are in flight (in the pipeline or queued); the
//     credit count drops as the serialiser takes a word from the queue
//   the receiver cannot stall: characters are never held and are lost if not sampled
//   reset (arst_n low) empties the pipeline, queue and serialiser at once; busy is low
//     and strobe low right after
module binary_to_decimal_ascii_unit #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [b2da_pkg::BIN_W-1:0]    value,
	output logic                          busy,
	output logic                          strobe,
	output logic [b2da_pkg::CHAR_W-1:0]   digit_char,
	output logic                          last
);

	localparam int CRD_W = $clog2(QUEUE_DEPTH + 1);

	logic               accept;
	logic               pop;
	logic               empty;
	logic [CRD_W-1:0]   credit_q;
	b2da_pkg::push_t    push_w;
	b2da_pkg::entry_t   head_w;

	assign busy   = (credit_q == CRD_W'(QUEUE_DEPTH));
	assign accept = start && !busy;

	// words in flight: bounds queue occupancy so a push never finds it full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({accept, pop})
				2'b10:   credit_q <= credit_q + CRD_W'(1);
				2'b01:   credit_q <= credit_q - CRD_W'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

	// front: binary to bcd, digit count and alignment
	b2da_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.value    (value),
		.push_out (push_w)
	);

	b2da_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_in (push_w),
		.pop     (pop),
		.head    (head_w),
		.empty   (empty)
	);

	// back: one ascii character per cycle while a word is loaded
	b2da_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_w),
		.empty      (empty),
		.pop        (pop),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

### rtl/b2da_checker.sv
// b2da_checker: port-level assertions for binary_to_decimal_ascii_unit, with its bind
// depends on b2da_pkg and the top level
`timescale 1ns / 1ps

module b2da_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic [b2da_pkg::BIN_W-1:0]    value,
	input logic                          busy,
	input logic                          strobe,
	input logic [b2da_pkg::CHAR_W-1:0]   digit_char,
	input logic                          last
);

	logic open_run;
	assign open_run = strobe && !last;

	// characters of one word leave on consecutive cycles
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		open_run |=> strobe)
		else $error("gap inside a digit run");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (digit_char >= 6'd48 && digit_char <= 6'd57))
		else $error("character is not a decimal digit");

	// first digit of a multi-digit run is never a leading zero
	a_no_leading_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(open_run && !$past(open_run)) |-> (digit_char != b2da_pkg::ASCII_ZERO))
		else $error("leading zero sent");

	// at most five digits per word
	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && $past(open_run, 1) && $past(open_run, 2) && $past(open_run, 3)
			&& $past(open_run, 4)) |-> last)
		else $error("digit run longer than five");

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_b2da_checker (.*);
